@@ hdl/espc_pkg.sv @@
`timescale 1ns / 1ps
// Shared widths, codes and types of the encoder speed PI controller.
package espc_pkg;

	localparam int AVG_DEPTH_DEF = 8;

	localparam int CNT_W       = 16;
	localparam int RPM_W       = 24;
	localparam int DUTY_W      = 8;
	localparam int CMP_W       = 10;
	localparam int GAIN_W      = 16;
	localparam int INTEG_W     = 48;
	localparam int CFG_W       = 16;
	localparam int REG_IDX_W   = 3;
	localparam int TDATA_OUT_W = 48;

	localparam int ACC_W  = 65;
	localparam int DIVD_W = 36;
	localparam int DVSR_W = 16;
	localparam int MR_W   = 23;
	localparam int STEP_W = 6;

	localparam logic [REG_IDX_W-1:0] REG_TARGET = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ENABLE = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CPR    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KP     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_KI     = 3'd4;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} alu_op_t;

	typedef struct packed {
		logic              start;
		alu_op_t           op;
		logic              acc_keep;
		logic [STEP_W-1:0] steps;
	} alu_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
	} alu_stat_t;

endpackage

@@ hdl/espc_ram.sv @@
`timescale 1ns / 1ps
// Generic single-port-write, registered-read RAM.
module espc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hdl/espc_alu.sv @@
`timescale 1ns / 1ps
// Shared iterative unit: shift-add signed multiply and restoring divide on one adder.
module espc_alu import espc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  alu_cmd_t         cmd,
	input  logic [ACC_W-1:0] opnd_a,
	input  logic [MR_W-1:0]  opnd_b,
	output alu_stat_t        stat,
	output logic [ACC_W-1:0] result
);

	logic              busy_q;
	logic              done_q;
	alu_op_t           op_q;
	logic [STEP_W-1:0] steps_q;
	logic [ACC_W-1:0]  wide_q;
	logic [ACC_W-1:0]  acc_q;
	logic [MR_W-1:0]   mr_q;

	logic [ACC_W-1:0]  add_a;
	logic [ACC_W-1:0]  add_b;
	logic              cin;
	logic [ACC_W-1:0]  sum;
	logic              last;
	logic              ge;
	logic [DVSR_W:0]   rem_sh;

	always_comb begin
		last   = (steps_q == STEP_W'(1));
		rem_sh = {acc_q[DVSR_W-1:0], wide_q[DIVD_W-1]};
		if (op_q == OP_DIV) begin
			add_a = ACC_W'(rem_sh);
			add_b = ~ACC_W'(mr_q[DVSR_W-1:0]);
			cin   = 1'b1;
		end else begin
			add_a = acc_q;
			add_b = mr_q[0] ? (last ? ~wide_q : wide_q) : '0;
			cin   = mr_q[0] & last;
		end
		sum = add_a + add_b + ACC_W'(cin);
		ge  = ~sum[ACC_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			op_q    <= OP_MUL;
			steps_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q  <= 1'b1;
				op_q    <= cmd.op;
				steps_q <= cmd.steps;
			end else if (busy_q) begin
				steps_q <= steps_q - STEP_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			wide_q <= opnd_a;
			mr_q   <= opnd_b;
			if (cmd.op == OP_DIV || !cmd.acc_keep) begin
				acc_q <= '0;
			end
		end else if (busy_q) begin
			if (op_q == OP_DIV) begin
				acc_q  <= ge ? sum : ACC_W'(rem_sh);
				wide_q <= {wide_q[ACC_W-2:0], ge};
			end else begin
				acc_q  <= sum;
				wide_q <= {wide_q[ACC_W-2:0], 1'b0};
				mr_q   <= {1'b0, mr_q[MR_W-1:1]};
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign result    = (op_q == OP_DIV) ? wide_q : acc_q;

endmodule

@@ hdl/encoder_speed_pi_controller_top.sv @@
`timescale 1ns / 1ps
// Encoder speed measurement with moving average and PI speed controller, top level.
//
// One item is in work at a time; s_axis_tready is high only while the block waits
// for an item. The time per item is set by one shared shift-add/subtract unit that
// does a bit per cycle. A measure item takes a 36-step divide for the speed and a
// divide of the window sum by the entry count. An enabled control item takes two
// 23-step multiplies for the proportional and integral terms. A control item while
// disabled goes straight to the output. A finished result sits in the output
// register, so the next item is taken while it waits. The window entries live in a
// RAM with undefined contents after reset; an entry is read only once written.
module encoder_speed_pi_controller_top import espc_pkg::*; #(
	parameter int AVERAGE_DEPTH = AVG_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [CNT_W-1:0]       s_axis_tdata,   // [15:0] encoder_count
	input  logic                   s_axis_tuser,   // [0] func
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [TDATA_OUT_W-1:0] m_axis_tdata,   // [23:0] avg_rpm, [31:24] speed_duty,
	                                               // [41:32] pwm_compare, [47:42] zero
	output logic                   m_axis_tuser,   // [0] pwm_written
	input  logic                   cfg_we,
	input  logic [REG_IDX_W-1:0]   cfg_idx,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int PW    = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
	localparam int SUM_W = RPM_W + $clog2(AVERAGE_DEPTH);
	localparam int N_W   = $clog2(AVERAGE_DEPTH + 1);
	localparam int ERR_W = 26;
	localparam int MAG_W = CNT_W + 1;
	localparam int PROD_W = 38;

	localparam int RPM_SCALE    = 1536000;
	localparam int DIV5_RECIP   = 52429;
	localparam int DIV100_RECIP = 5243;
	localparam int CMP_RECIP    = 134050627;
	localparam int TOTAL_SAT    = 10100;
	localparam int SPD_SAT      = 1280;
	localparam int DUTY_MAX     = 100;
	localparam int CMP_MAX      = 799;
	localparam int CPR_RESET    = 1024;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MEAS,
		S_RPM_GO,
		S_RPM_WAIT,
		S_SUM,
		S_AVG_GO,
		S_AVG_WAIT,
		S_ERR,
		S_INTEG,
		S_KP_GO,
		S_KP_WAIT,
		S_KI_GO,
		S_KI_WAIT,
		S_DUTY,
		S_CMP,
		S_OUT
	} state_t;

	function automatic logic [DUTY_W-1:0] speed_duty_of(input logic [RPM_W-1:0] avg);
		logic [14:0] x;
		logic [26:0] p;
		x = avg[RPM_W-1:9];
		p = {16'b0, x[10:0]} * 27'(DIV5_RECIP);
		if (x >= 15'(SPD_SAT)) begin
			return '1;
		end
		return p[25:18];
	endfunction

	function automatic logic [6:0] duty_of_total(input logic [ACC_W-1:0] t);
		logic [13:0] x;
		logic [26:0] p;
		x = t[29:16];
		p = {13'b0, x} * 27'(DIV100_RECIP);
		if (t[ACC_W-1] || t == '0) begin
			return '0;
		end
		if (t[ACC_W-1:16] >= (ACC_W-16)'(TOTAL_SAT)) begin
			return 7'(DUTY_MAX);
		end
		return p[25:19];
	endfunction

	function automatic logic [CMP_W-1:0] compare_of(input logic [6:0] d);
		logic [34:0] p;
		p = {28'b0, d} * 35'(CMP_RECIP);
		return p[33:24];
	endfunction

	state_t                   state_q;
	logic [CNT_W-1:0]         target_q;
	logic                     en_q;
	logic [CNT_W-1:0]         cpr_q;
	logic [GAIN_W-1:0]        kp_q;
	logic [GAIN_W-1:0]        ki_q;
	logic [CNT_W-1:0]         last_q;
	logic [PW-1:0]            pos_q;
	logic                     full_q;
	logic [SUM_W-1:0]         sum_q;
	logic [RPM_W-1:0]         avg_q;
	logic signed [INTEG_W-1:0] integ_q;
	logic [CMP_W-1:0]         cmp_q;
	logic                     wr_q;

	logic [CNT_W-1:0]         count_q;
	logic [DIVD_W-1:0]        prod_q;
	logic [RPM_W-1:0]         rpm_q;
	logic [N_W-1:0]           n_q;
	logic signed [ERR_W-1:0]  err_q;
	logic [6:0]               duty_q;

	logic [CNT_W-1:0]         diff;
	logic [MAG_W-1:0]         mag;
	logic [PROD_W-1:0]        prod_full;
	logic [DVSR_W-1:0]        divisor;
	logic [RPM_W-1:0]         old_rpm;
	logic [RPM_W-1:0]         rpm_sat;
	logic [SUM_W-1:0]         sum_nxt;
	logic [PW-1:0]            pos_nxt;
	logic                     wrap;
	logic                     full_nxt;
	logic [N_W-1:0]           n_nxt;
	logic signed [ERR_W-1:0]  err_nxt;
	logic signed [INTEG_W:0]  integ_sum;
	logic signed [INTEG_W-1:0] integ_nxt;
	logic signed [MR_W-1:0]   kp_ext;
	logic signed [MR_W-1:0]   kp100;

	alu_cmd_t                 alu_cmd;
	alu_stat_t                alu_st;
	logic [ACC_W-1:0]         opnd_a;
	logic [MR_W-1:0]          opnd_b;
	logic [ACC_W-1:0]         alu_res;

	assign s_axis_tready = (state_q == S_IDLE);

	always_comb begin
		diff      = count_q - last_q;
		mag       = diff[CNT_W-1] ? (MAG_W'(1) << CNT_W) - {1'b0, diff} : {1'b0, diff};
		prod_full = {{(PROD_W-MAG_W){1'b0}}, mag} * PROD_W'(RPM_SCALE);
		divisor   = (cpr_q == '0) ? DVSR_W'(1) : cpr_q;
		rpm_sat   = (|alu_res[DIVD_W-1:RPM_W]) ? '1 : alu_res[RPM_W-1:0];
		sum_nxt   = sum_q - (full_q ? SUM_W'(old_rpm) : '0) + SUM_W'(rpm_q);
		wrap      = (pos_q == PW'(AVERAGE_DEPTH - 1));
		pos_nxt   = wrap ? '0 : PW'(pos_q + 1'b1);
		full_nxt  = full_q | wrap;
		n_nxt     = full_nxt ? N_W'(AVERAGE_DEPTH) : N_W'(pos_nxt);
		err_nxt   = $signed({2'b0, target_q, 8'b0}) - $signed({2'b0, avg_q});
		integ_sum = $signed({integ_q[INTEG_W-1], integ_q})
		            + $signed({{(INTEG_W+1-ERR_W){err_q[ERR_W-1]}}, err_q});
		if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
			integ_nxt = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
			                               : {1'b0, {(INTEG_W-1){1'b1}}};
		end else begin
			integ_nxt = integ_sum[INTEG_W-1:0];
		end
		kp_ext = $signed({{(MR_W-GAIN_W){kp_q[GAIN_W-1]}}, kp_q});
		kp100  = (kp_ext <<< 6) + (kp_ext <<< 5) + (kp_ext <<< 2);
	end

	always_comb begin
		alu_cmd = '0;
		opnd_a  = '0;
		opnd_b  = '0;
		unique case (state_q)
			S_RPM_GO: begin
				alu_cmd.start = 1'b1;
				alu_cmd.op    = OP_DIV;
				alu_cmd.steps = STEP_W'(DIVD_W);
				opnd_a        = ACC_W'(prod_q);
				opnd_b        = MR_W'(divisor);
			end
			S_AVG_GO: begin
				alu_cmd.start = 1'b1;
				alu_cmd.op    = OP_DIV;
				alu_cmd.steps = STEP_W'(SUM_W);
				opnd_a        = ACC_W'({sum_q, {(DIVD_W-SUM_W){1'b0}}});
				opnd_b        = MR_W'(n_q);
			end
			S_KP_GO: begin
				alu_cmd.start = 1'b1;
				alu_cmd.op    = OP_MUL;
				alu_cmd.steps = STEP_W'(MR_W);
				opnd_a        = {{(ACC_W-ERR_W){err_q[ERR_W-1]}}, err_q};
				opnd_b        = kp100;
			end
			S_KI_GO: begin
				alu_cmd.start    = 1'b1;
				alu_cmd.op       = OP_MUL;
				alu_cmd.acc_keep = 1'b1;
				alu_cmd.steps    = STEP_W'(MR_W);
				opnd_a           = {{(ACC_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q};
				opnd_b           = {{(MR_W-GAIN_W){ki_q[GAIN_W-1]}}, ki_q};
			end
			default: begin
			end
		endcase
	end

	espc_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (alu_cmd),
		.opnd_a (opnd_a),
		.opnd_b (opnd_b),
		.stat   (alu_st),
		.result (alu_res)
	);

	espc_ram #(
		.WIDTH (RPM_W),
		.DEPTH (AVERAGE_DEPTH)
	) u_window (
		.clk   (clk),
		.we    (state_q == S_SUM),
		.waddr (pos_q),
		.wdata (rpm_q),
		.re    (state_q == S_MEAS && full_q),
		.raddr (pos_q),
		.rdata (old_rpm)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			target_q      <= '0;
			en_q          <= 1'b0;
			cpr_q         <= CNT_W'(CPR_RESET);
			kp_q          <= '0;
			ki_q          <= '0;
			last_q        <= '0;
			pos_q         <= '0;
			full_q        <= 1'b0;
			sum_q         <= '0;
			avg_q         <= '0;
			integ_q       <= '0;
			cmp_q         <= '0;
			wr_q          <= 1'b0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata  <= '0;
			m_axis_tuser  <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready && state_q != S_OUT) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						wr_q <= s_axis_tuser & en_q;
						if (!s_axis_tuser) begin
							state_q <= S_MEAS;
						end else if (en_q) begin
							state_q <= S_ERR;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_MEAS: begin
					last_q  <= count_q;
					state_q <= S_RPM_GO;
				end
				S_RPM_GO:   state_q <= S_RPM_WAIT;
				S_RPM_WAIT: begin
					if (alu_st.done) begin
						state_q <= S_SUM;
					end
				end
				S_SUM: begin
					sum_q   <= sum_nxt;
					pos_q   <= pos_nxt;
					full_q  <= full_nxt;
					state_q <= S_AVG_GO;
				end
				S_AVG_GO:   state_q <= S_AVG_WAIT;
				S_AVG_WAIT: begin
					if (alu_st.done) begin
						avg_q   <= alu_res[RPM_W-1:0];
						state_q <= S_OUT;
					end
				end
				S_ERR:      state_q <= S_INTEG;
				S_INTEG: begin
					integ_q <= integ_nxt;
					state_q <= S_KP_GO;
				end
				S_KP_GO:    state_q <= S_KP_WAIT;
				S_KP_WAIT: begin
					if (alu_st.done) begin
						state_q <= S_KI_GO;
					end
				end
				S_KI_GO:    state_q <= S_KI_WAIT;
				S_KI_WAIT: begin
					if (alu_st.done) begin
						state_q <= S_DUTY;
					end
				end
				S_DUTY:     state_q <= S_CMP;
				S_CMP: begin
					cmp_q   <= compare_of(duty_q);
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_axis_tvalid || m_axis_tready) begin
						m_axis_tvalid <= 1'b1;
						m_axis_tdata  <= {{(TDATA_OUT_W-CMP_W-DUTY_W-RPM_W){1'b0}},
						                  cmp_q, speed_duty_of(avg_q), avg_q};
						m_axis_tuser  <= wr_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (cfg_we) begin
				case (cfg_idx)
					REG_TARGET: begin
						target_q <= cfg_data;
						integ_q  <= '0;
					end
					REG_ENABLE: begin
						en_q <= cfg_data[0];
						if (!cfg_data[0]) begin
							integ_q <= '0;
						end
					end
					REG_CPR: cpr_q <= cfg_data;
					REG_KP:  kp_q  <= cfg_data;
					REG_KI:  ki_q  <= cfg_data;
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && s_axis_tvalid) begin
			count_q <= s_axis_tdata;
		end
		if (state_q == S_MEAS) begin
			prod_q <= prod_full[DIVD_W-1:0];
		end
		if (state_q == S_RPM_WAIT && alu_st.done) begin
			rpm_q <= rpm_sat;
		end
		if (state_q == S_SUM) begin
			n_q <= n_nxt;
		end
		if (state_q == S_ERR) begin
			err_q <= err_nxt;
		end
		if (state_q == S_DUTY) begin
			duty_q <= duty_of_total(alu_res);
		end
	end

	a_ready_alu_free: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !alu_st.busy)
		else $error("item taken while the shared unit is busy");

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= PW'(AVERAGE_DEPTH - 1))
		else $error("window position beyond depth");

	a_integ_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_idx == REG_TARGET) |=> (integ_q == '0))
		else $error("integral not cleared by target write");

	a_cmp_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmp_q <= CMP_W'(CMP_MAX))
		else $error("compare value above period");

endmodule

@@ dv/tb_encoder_speed_pi_controller_top.sv @@
`timescale 1ns / 1ps
// Stream testbench for the encoder speed PI controller: directed table, random phases, scoreboard.
module tb_encoder_speed_pi_controller_top import espc_pkg::*;;

	localparam int           DEPTH          = AVG_DEPTH_DEF;
	localparam int           PAD_W          = TDATA_OUT_W - RPM_W - DUTY_W - CMP_W;
	localparam int           RAND_PHASES    = 10;
	localparam int           PHASE_ITEMS    = 190;
	localparam int           QUIET_LIMIT    = 4000;
	localparam int           SETTLE_CYCLES  = 100;
	localparam logic         FUNC_MEASURE   = 1'b0;
	localparam logic         FUNC_CONTROL   = 1'b1;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = REG_KI + 3'd1;
	localparam longint       INTEG_HI       = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint       INTEG_LO       = -INTEG_HI - 1;

	typedef struct packed {
		logic                 written;
		logic [PAD_W-1:0]     pad;
		logic [CMP_W-1:0]     cmp;
		logic [DUTY_W-1:0]    duty;
		logic [RPM_W-1:0]     avg;
	} speed_result_t;

	typedef struct packed {
		bit            pinned;
		speed_result_t res;
	} pinned_result_t;

	typedef enum logic {
		DIR_ITEM,
		DIR_REG
	} dir_kind_t;

	typedef struct packed {
		dir_kind_t            kind;
		logic                 func;
		logic [REG_IDX_W-1:0] reg_idx;
		logic [CNT_W-1:0]     val;
		bit                   pinned;
		speed_result_t        res;
	} dir_step_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [CNT_W-1:0]       s_axis_tdata;   // [15:0] encoder_count
	logic                   s_axis_tuser;   // [0] func
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [TDATA_OUT_W-1:0] m_axis_tdata;   // [23:0] avg_rpm, [31:24] speed_duty,
	                                        // [41:32] pwm_compare, [47:42] zero
	logic                   m_axis_tuser;   // [0] pwm_written
	logic                   cfg_we;
	logic [REG_IDX_W-1:0]   cfg_idx;
	logic [CFG_W-1:0]       cfg_data;

	bit                     stall_mode = 1'b1;
	int                     fault_count = 0;
	int                     quiet_cycles = 0;
	speed_result_t          pending_results[$];
	pinned_result_t         pinned_results[$];

	logic [CNT_W-1:0]       set_rpm = '0;
	bit                     run_en = 1'b0;
	logic [CNT_W-1:0]       cpr_q = 16'd1024;
	logic signed [GAIN_W-1:0] kp_q = '0;
	logic signed [GAIN_W-1:0] ki_q = '0;

	logic [CNT_W-1:0]       prev_count = '0;
	logic [RPM_W-1:0]       rpm_ring [DEPTH];
	int unsigned            ring_slot = 0;
	bit                     ring_full = 1'b0;
	longint unsigned        ring_sum = 0;
	logic [RPM_W-1:0]       rpm_avg = '0;
	longint                 err_accum = 0;
	logic [CMP_W-1:0]       compare_q = '0;

	dir_step_t plan [36] = '{
		'{DIR_ITEM, FUNC_CONTROL, '0, 16'h0000, 1'b1, '0},
		'{DIR_ITEM, FUNC_MEASURE, '0, 16'h0000, 1'b1, '0},
		'{DIR_ITEM, FUNC_MEASURE, '0, 16'hFFFF, 1'b0, '0},
		'{DIR_ITEM, FUNC_MEASURE, '0, 16'h7FFF, 1'b0, '0},
		'{DIR_ITEM, FUNC_MEASURE, '0, 16'hFFFF, 1'b0, '0},
		'{DIR_ITEM, FUNC_MEASURE, '0, 16'h8000, 1'b0, '0},
		'{DIR_REG,  '0, REG_CPR,    16'h0000, 1'b0, '0},
		'{DIR_ITEM, FUNC_MEASURE, '0, 16'h8000, 1'b0, '0},
		'{DIR_ITEM, FUNC_MEASURE, '0, 16'h8020, 1'b0, '0},
		'{DIR_REG,  '0, REG_CPR,    16'hFFFF, 1'b0, '0},
		'{DIR_ITEM, FUNC_MEASURE, '0, 16'h0020, 1'b0, '0},
		'{DIR_ITEM, FUNC_MEASURE, '0, 16'h0021, 1'b0, '0},
		'{DIR_REG,  '0, REG_TARGET, 16'hFFFF, 1'b0, '0},
		'{DIR_REG,  '0, REG_KP,     16'h7FFF, 1'b0, '0},
		'{DIR_REG,  '0, REG_KI,     16'h7FFF, 1'b0, '0},
		'{DIR_REG,  '0, REG_ENABLE, 16'h0001, 1'b0, '0},
		'{DIR_ITEM, FUNC_CONTROL, '0, 16'hA5A5, 1'b0, '0},
		'{DIR_ITEM, FUNC_CONTROL, '0, 16'h5A5A, 1'b0, '0},
		'{DIR_REG,  '0, REG_KP,     16'h8000, 1'b0, '0},
		'{DIR_REG,  '0, REG_KI,     16'h8000, 1'b0, '0},
		'{DIR_ITEM, FUNC_CONTROL, '0, 16'h0000, 1'b0, '0},
		'{DIR_REG,  '0, REG_ENABLE, 16'hFFFE, 1'b0, '0},
		'{DIR_REG,  '0, REG_SPARE_LO, 16'hFFFF, 1'b0, '0},
		'{DIR_REG,  '0, '1,         16'hFFFF, 1'b0, '0},
		'{DIR_ITEM, FUNC_CONTROL, '0, 16'hFFFF, 1'b0, '0},
		'{DIR_REG,  '0, REG_ENABLE, 16'h0001, 1'b0, '0},
		'{DIR_REG,  '0, REG_TARGET, 16'h0000, 1'b0, '0},
		'{DIR_REG,  '0, REG_KP,     16'h0100, 1'b0, '0},
		'{DIR_REG,  '0, REG_KI,     16'h0010, 1'b0, '0},
		'{DIR_REG,  '0, REG_CPR,    16'h0400, 1'b0, '0},
		'{DIR_ITEM, FUNC_MEASURE, '0, 16'h0400, 1'b0, '0},
		'{DIR_ITEM, FUNC_CONTROL, '0, 16'h0000, 1'b0, '0},
		'{DIR_ITEM, FUNC_MEASURE, '0, 16'h0800, 1'b0, '0},
		'{DIR_ITEM, FUNC_CONTROL, '0, 16'h0000, 1'b0, '0},
		'{DIR_ITEM, FUNC_MEASURE, '0, 16'h0400, 1'b0, '0},
		'{DIR_ITEM, FUNC_CONTROL, '0, 16'h0000, 1'b0, '0}
	};

	encoder_speed_pi_controller_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void apply_reg(input logic [REG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] val);
		case (idx)
			REG_TARGET: begin
				set_rpm = val;
				err_accum = 0;
			end
			REG_ENABLE: begin
				run_en = val[0];
				if (!run_en) err_accum = 0;
			end
			REG_CPR: cpr_q = val;
			REG_KP: kp_q = val;
			REG_KI: ki_q = val;
			default: ;
		endcase
	endfunction

	function automatic void speed_measure(input logic [CNT_W-1:0] cnt);
		logic [CNT_W-1:0] diff;
		longint unsigned mag, dv, rpm;
		int unsigned n;
		diff = cnt - prev_count;
		mag = diff[CNT_W-1] ? 65536 - diff : diff;
		dv = (cpr_q == 0) ? 1 : cpr_q;
		rpm = mag * 1536000 / dv;
		if (rpm > 24'hFFFFFF) rpm = 24'hFFFFFF;
		prev_count = cnt;
		if (ring_full) ring_sum -= rpm_ring[ring_slot];
		rpm_ring[ring_slot] = rpm[RPM_W-1:0];
		ring_sum += rpm;
		ring_slot++;
		if (ring_slot == DEPTH) begin
			ring_slot = 0;
			ring_full = 1'b1;
		end
		n = ring_full ? DEPTH : ring_slot;
		rpm_avg = RPM_W'(ring_sum / n);
	endfunction

	function automatic bit pi_tick();
		longint err, total, q;
		int duty;
		if (!run_en) return 1'b0;
		err = longint'(set_rpm) * 256 - longint'(rpm_avg);
		err_accum += err;
		if (err_accum > INTEG_HI) err_accum = INTEG_HI;
		if (err_accum < INTEG_LO) err_accum = INTEG_LO;
		total = 100 * longint'(kp_q) * err + longint'(ki_q) * err_accum;
		if (total <= 0) begin
			duty = 0;
		end else begin
			q = total / 6553600;
			duty = (q > 100) ? 100 : int'(q);
		end
		compare_q = CMP_W'(duty * 799 / 100);
		return 1'b1;
	endfunction

	function automatic void note_fault(input string what, input speed_result_t got,
			input speed_result_t want);
		fault_count++;
		if (fault_count <= 10)
			$display("%0t %s: expected avg=%h duty=%0d cmp=%0d wr=%b pad=%h,",
				$time, what, want.avg, want.duty, want.cmp, want.written, want.pad,
				" got avg=%h duty=%0d cmp=%0d wr=%b pad=%h",
				got.avg, got.duty, got.cmp, got.written, got.pad);
	endfunction

	always @(posedge clk) begin : scoreboard
		speed_result_t  got, want;
		pinned_result_t pin;
		bit             wrote, moved;
		moved = 1'b0;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				moved = 1'b1;
				got = {m_axis_tuser, m_axis_tdata};
				if (pending_results.size() == 0) begin
					note_fault("unexpected result", got, '0);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) note_fault("result mismatch", got, want);
				end
			end
			if (cfg_we) begin
				moved = 1'b1;
				apply_reg(cfg_idx, cfg_data);
			end
			if (s_axis_tvalid && s_axis_tready) begin
				moved = 1'b1;
				pin = pinned_results.pop_front();
				wrote = 1'b0;
				if (s_axis_tuser == FUNC_CONTROL) wrote = pi_tick();
				else speed_measure(s_axis_tdata);
				want.written = wrote;
				want.pad = '0;
				want.cmp = compare_q;
				want.duty = (rpm_avg / 2560 > 255) ? 8'd255 : DUTY_W'(rpm_avg / 2560);
				want.avg = rpm_avg;
				pending_results.push_back(pin.pinned ? pin.res : want);
			end
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("encoder_speed_pi_controller_top verification failed");
			$finish;
		end
	end

	initial begin : receiver
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			m_axis_tready <= !stall_mode || ($urandom_range(99) >= 34);
		end
	end

	task automatic push_item(input logic f, input logic [CNT_W-1:0] cnt, input bit pinned,
			input speed_result_t res);
		while (stall_mode && $urandom_range(99) < 34) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		pinned_results.push_back('{pinned, res});
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= f;
		s_axis_tdata <= cnt;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	initial begin : stimulus
		logic [CNT_W-1:0] enc_pos, stride;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = FUNC_MEASURE;
		cfg_we = 1'b0;
		cfg_idx = REG_TARGET;
		cfg_data = '0;
		enc_pos = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == DIR_REG) begin
				quiesce();
				write_reg(plan[i].reg_idx, plan[i].val);
			end else begin
				push_item(plan[i].func, plan[i].val, plan[i].pinned, plan[i].res);
			end
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			quiesce();
			stall_mode = !(ph == 4 || ph == 5);
			if (ph == 0) begin
				write_reg(REG_TARGET, 16'hFFFF);
				write_reg(REG_CPR, 16'hFFFF);
				write_reg(REG_KP, 16'h7FFF);
				write_reg(REG_KI, 16'h7FFF);
				write_reg(REG_ENABLE, 16'h0001);
			end else if (ph == 1) begin
				write_reg(REG_TARGET, 16'h0000);
				write_reg(REG_CPR, 16'h0000);
				write_reg(REG_KP, 16'h8000);
				write_reg(REG_KI, 16'h8000);
				write_reg(REG_ENABLE, 16'h0001);
			end else begin
				if ($urandom_range(3) != 0)
					case ($urandom_range(4))
						0: write_reg(REG_TARGET, 16'h0000);
						1: write_reg(REG_TARGET, 16'hFFFF);
						2: write_reg(REG_TARGET, 16'($urandom));
						default: write_reg(REG_TARGET, 16'($urandom_range(0, 6000)));
					endcase
				if ($urandom_range(3) != 0)
					case ($urandom_range(5))
						0: write_reg(REG_CPR, 16'h0000);
						1: write_reg(REG_CPR, 16'h0001);
						2: write_reg(REG_CPR, 16'hFFFF);
						default: write_reg(REG_CPR, 16'($urandom_range(256, 4096)));
					endcase
				if ($urandom_range(3) != 0)
					case ($urandom_range(5))
						0: write_reg(REG_KP, 16'h8000);
						1: write_reg(REG_KP, 16'h7FFF);
						2: write_reg(REG_KP, 16'($urandom));
						3: write_reg(REG_KP, -16'($urandom_range(0, 64)));
						default: write_reg(REG_KP, 16'($urandom_range(0, 64)));
					endcase
				if ($urandom_range(3) != 0)
					case ($urandom_range(5))
						0: write_reg(REG_KI, 16'h8000);
						1: write_reg(REG_KI, 16'h7FFF);
						2: write_reg(REG_KI, 16'($urandom));
						3: write_reg(REG_KI, -16'($urandom_range(0, 64)));
						default: write_reg(REG_KI, 16'($urandom_range(0, 64)));
					endcase
				if ($urandom_range(3) != 0)
					write_reg(REG_ENABLE, {15'($urandom), 1'($urandom_range(7) != 0)});
				if ($urandom_range(4) == 0)
					write_reg(REG_SPARE_LO + REG_IDX_W'($urandom_range(0, 2)), 16'($urandom));
			end

			stride = ($urandom_range(7) == 0) ? 16'($urandom_range(0, 32768))
				: 16'($urandom_range(0, 400));
			if ($urandom_range(1)) stride = -stride;
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(9) < 4) begin
					push_item(FUNC_CONTROL, 16'($urandom), 1'b0, '0);
				end else begin
					if ($urandom_range(19) == 0) enc_pos = 16'($urandom);
					else enc_pos = enc_pos + stride + 16'($urandom_range(0, 8)) - 16'd4;
					push_item(FUNC_MEASURE, enc_pos, 1'b0, '0);
				end
			end
		end

		quiesce();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fault_count == 0 && pending_results.size() == 0)
			$display("encoder_speed_pi_controller_top verification clean");
		else
			$display("encoder_speed_pi_controller_top verification failed");
		$finish;
	end

endmodule
